### hdl/lmc_pkg.sv
// lmc_pkg: shared types, micro-operation codes and the control store of the LRU tracker.
// No dependencies. Used by lmc_useq, lmc_dpath and the top level.
`timescale 1ns / 1ps

package lmc_pkg;

	localparam int ASSET_W = 10;

	// Program steps; the order sets the fall-through sequence.
	typedef enum logic [3:0] {
		S_CLR    = 4'd0,
		S_IDLE   = 4'd1,
		S_RANGE  = 4'd2,
		S_DECIDE = 4'd3,
		S_APPEND = 4'd4,
		S_WALK   = 4'd5,
		S_TAIL   = 4'd6,
		S_DROP   = 4'd7,
		S_SETMAP = 4'd8,
		S_REPORT = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_CLR_BUSY,
		C_NO_START,
		C_OUT_RANGE,
		C_WALK_GO,
		C_WALK_MORE,
		C_NOT_FOUND
	} cond_t;

	typedef enum logic [1:0] {
		M_NONE,
		M_CLEAR,
		M_DROP,
		M_SET
	} map_op_t;

	typedef enum logic [1:0] {
		L_NONE,
		L_SHIFT,
		L_TAIL,
		L_APPEND
	} list_op_t;

	typedef struct packed {
		cond_t    cond;
		step_t    target;
		logic     accept;
		logic     rd_clr;
		logic     rd_inc;
		logic     set_mode;
		map_op_t  map_op;
		list_op_t list_op;
		logic     report;
	} uop_t;

	typedef struct packed {
		logic clr_last;
		logic out_range;
		logic walk_go;
		logic walk_more;
		logic found;
	} flags_t;

	localparam uop_t UOP_NOP = '{cond: C_ALWAYS, target: S_IDLE, accept: 1'b0, rd_clr: 1'b0,
		rd_inc: 1'b0, set_mode: 1'b0, map_op: M_NONE, list_op: L_NONE, report: 1'b0};

	// Control store
	function automatic uop_t rom(input step_t s);
		uop_t u;
		u = UOP_NOP;
		unique case (s)
			S_CLR: begin
				u.cond = C_CLR_BUSY; u.target = S_CLR; u.map_op = M_CLEAR;
			end
			S_IDLE: begin
				u.cond = C_NO_START; u.target = S_IDLE; u.accept = 1'b1;
			end
			S_RANGE: begin
				u.cond = C_OUT_RANGE; u.target = S_REPORT; u.rd_clr = 1'b1;
			end
			S_DECIDE: begin
				u.cond = C_WALK_GO; u.target = S_WALK; u.rd_inc = 1'b1; u.set_mode = 1'b1;
			end
			S_APPEND: begin
				u.cond = C_ALWAYS; u.target = S_SETMAP; u.list_op = L_APPEND;
			end
			S_WALK: begin
				u.cond = C_WALK_MORE; u.target = S_WALK; u.rd_inc = 1'b1; u.list_op = L_SHIFT;
			end
			S_TAIL: begin
				u.cond = C_NOT_FOUND; u.target = S_APPEND; u.list_op = L_TAIL;
			end
			S_DROP: begin
				u.cond = C_NEXT; u.map_op = M_DROP;
			end
			S_SETMAP: begin
				u.cond = C_NEXT; u.map_op = M_SET;
			end
			S_REPORT: begin
				u.cond = C_ALWAYS; u.target = S_IDLE; u.report = 1'b1;
			end
			default: u = UOP_NOP;
		endcase
		return u;
	endfunction

endpackage

### hdl/lru_mapping_cache_policy.sv
// lru_mapping_cache_policy: top level of the LRU residency tracker.
// Depends on lmc_pkg, lmc_useq, lmc_dpath (and lmc_ram beneath it).
`timescale 1ns / 1ps

// Channel   Signals                                        Handshake
// --------  ---------------------------------------------  ---------------------------------
// request   asset_index                                    taken on start && !busy
// result    hit, evicted_valid, evicted_asset              valid for one cycle with done
//
// After reset the residency map is cleared one entry a cycle, with busy high throughout.
// A miss with room left steps through the range, decide, append, set-map and report steps.
// A hit, or a miss that evicts, walks the recency list once through its read port.
// One transaction is in flight at a time; the receiver cannot stall, and the result register
// lets the next request be taken in the same cycle as done.

module lru_mapping_cache_policy #(
	parameter int LIMIT      = 128,
	parameter int NUM_ASSETS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [9:0] asset_index,
	output logic       done,
	output logic       hit,
	output logic       evicted_valid,
	output logic [9:0] evicted_asset
);

	import lmc_pkg::*;

	uop_t   uop;
	flags_t flags;

	// sequencer: steps the control store, jumps on datapath flags
	lmc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.uop    (uop),
		.busy   (busy)
	);

	// datapath: recency list, residency map, walk compare/shift, result register
	lmc_dpath #(
		.LIMIT      (LIMIT),
		.NUM_ASSETS (NUM_ASSETS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.asset_index   (asset_index),
		.uop           (uop),
		.flags         (flags),
		.done          (done),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_asset (evicted_asset)
	);

endmodule

### hdl/lmc_ram.sv
// lmc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/lmc_useq.sv
// lmc_useq: step counter, control store lookup and conditional jump logic.
// Depends on lmc_pkg.
`timescale 1ns / 1ps

module lmc_useq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lmc_pkg::flags_t flags,
	output lmc_pkg::uop_t uop,
	output logic          busy
);

	import lmc_pkg::*;

	step_t upc_q;
	step_t upc_d;
	logic  take;

	// next step
	always_comb begin
		unique case (uop.cond)
			C_NEXT:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_CLR_BUSY:  take = !flags.clr_last;
			C_NO_START:  take = !start;
			C_OUT_RANGE: take = flags.out_range;
			C_WALK_GO:   take = flags.walk_go;
			C_WALK_MORE: take = flags.walk_more;
			C_NOT_FOUND: take = !flags.found;
			default:     take = 1'b1;
		endcase
		upc_d = take ? uop.target : step_t'(4'(upc_q) + 4'd1);
	end

	// control word
	always_comb begin
		uop  = rom(upc_q);
		busy = !uop.accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_CLR;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

### hdl/lmc_dpath.sv
// lmc_dpath: recency list RAM, residency map RAM, walk/shift logic and result registers.
// Depends on lmc_pkg and lmc_ram.
`timescale 1ns / 1ps

module lmc_dpath #(
	parameter int LIMIT      = 128,
	parameter int NUM_ASSETS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lmc_pkg::ASSET_W-1:0] asset_index,
	input  lmc_pkg::uop_t               uop,
	output lmc_pkg::flags_t             flags,
	output logic                        done,
	output logic                        hit,
	output logic                        evicted_valid,
	output logic [lmc_pkg::ASSET_W-1:0] evicted_asset
);

	import lmc_pkg::*;

	localparam int D  = LIMIT + 1;
	localparam int LW = $clog2(D);
	localparam int CW = $clog2(D + 1);
	localparam int AW = $clog2(NUM_ASSETS);
	localparam logic [16:0] NUM_A = 17'(NUM_ASSETS);

	logic [ASSET_W-1:0] asset_q, ev_asset_q, eva_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      count_q, rd_q, rd_m2, cnt_m1;
	logic               found_q, evict_q, done_q, hit_q, evv_q;

	logic               m_we;
	logic [AW-1:0]      m_waddr;
	logic [0:0]         m_wdata, m_rdata;
	logic               l_we;
	logic [LW-1:0]      l_waddr;
	logic [ASSET_W-1:0] l_wdata, l_rdata;

	logic in_list, match, full, old_ok, accept;

	assign accept  = uop.accept && start;
	assign rd_m2   = rd_q - CW'(2);
	assign cnt_m1  = count_q - CW'(1);
	assign full    = count_q == CW'(D);
	// list data on the read port belongs to slot rd_q-1
	assign in_list = rd_q <= count_q;
	assign match   = in_list && (evict_q ? (rd_q == CW'(1)) : (l_rdata == asset_q));
	assign old_ok  = {7'd0, ev_asset_q} < NUM_A;

	always_comb begin
		flags.clr_last  = clr_q == AW'(NUM_ASSETS - 1);
		flags.out_range = {7'd0, asset_q} >= NUM_A;
		flags.walk_go   = m_rdata[0] || full;
		flags.walk_more = rd_q < count_q;
		flags.found     = found_q;
	end

	always_comb begin
		l_we    = 1'b0;
		l_waddr = count_q[LW-1:0];
		l_wdata = asset_q;
		unique case (uop.list_op)
			L_SHIFT: begin
				l_we    = found_q && in_list;
				l_waddr = rd_m2[LW-1:0];
				l_wdata = l_rdata;
			end
			L_TAIL: begin
				l_we    = found_q;
				l_waddr = cnt_m1[LW-1:0];
			end
			L_APPEND: begin
				l_we    = !full;
			end
			default: l_we = 1'b0;
		endcase
	end

	always_comb begin
		m_we    = 1'b0;
		m_waddr = AW'(asset_q);
		m_wdata = 1'b0;
		unique case (uop.map_op)
			M_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
			end
			M_DROP: begin
				m_we    = evict_q && old_ok;
				m_waddr = AW'(ev_asset_q);
			end
			M_SET: begin
				m_we    = 1'b1;
				m_wdata = 1'b1;
			end
			default: m_we = 1'b0;
		endcase
	end

	lmc_ram #(.WIDTH(ASSET_W), .DEPTH(D)) u_list (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (rd_q[LW-1:0]),
		.rdata (l_rdata)
	);

	lmc_ram #(.WIDTH(1), .DEPTH(NUM_ASSETS)) u_map (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (AW'(asset_q)),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
			rd_q    <= '0;
			found_q <= 1'b0;
			evict_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (accept) begin
				found_q <= 1'b0;
				evict_q <= 1'b0;
			end
			if (uop.map_op == M_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (uop.rd_clr) begin
				rd_q <= '0;
			end else if (uop.rd_inc) begin
				rd_q <= rd_q + CW'(1);
			end
			if (uop.set_mode) begin
				evict_q <= !m_rdata[0] && full;
			end
			if (uop.list_op == L_SHIFT && !found_q && match) begin
				found_q <= 1'b1;
			end
			if (uop.list_op == L_APPEND && !full) begin
				count_q <= count_q + CW'(1);
			end
			done_q <= uop.report;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			asset_q <= asset_index;
		end
		if (uop.list_op == L_SHIFT && !found_q && match && evict_q) begin
			ev_asset_q <= l_rdata;
		end
		if (uop.report) begin
			hit_q <= found_q && !evict_q;
			evv_q <= evict_q;
			eva_q <= evict_q ? ev_asset_q : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign evicted_valid = evv_q;
	assign evicted_asset = eva_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(D)) else $error("resident count above list depth");
	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		uop.report && evict_q |-> found_q) else $error("eviction without oldest slot taken");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe longer than one cycle");
	a_hit_xor_ev: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(hit_q && evv_q)) else $error("hit and eviction on one transaction");
	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		l_we && uop.list_op == L_SHIFT |-> rd_q >= CW'(2)) else $error("shift below slot zero");
`endif

endmodule
